@@ rtl/core/bdq_pkg.sv @@
// Shared constants, codes and types for the bounded deque with search.
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [2:0] ACT_QUERY      = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_POP_BACK   = 3'd4;
  localparam logic [2:0] ACT_READ_AT    = 3'd5;
  localparam logic [2:0] ACT_REMOVE_AT  = 3'd6;
  localparam logic [2:0] ACT_FIND       = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] CELL_HOLD         = 2'd0;
  localparam logic [1:0] CELL_INSERT_FRONT = 2'd1;
  localparam logic [1:0] CELL_WRITE_AT     = 2'd2;
  localparam logic [1:0] CELL_SHIFT_FROM   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  at;
    logic signed [31:0] data;
  } cell_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic signed [31:0] key;
    logic [IDX_W-1:0]  pos;
  } scan_ctx_t;

  typedef struct packed {
    logic               any;
    logic               found;
    logic [IDX_W-1:0]   fpos;
    logic signed [31:0] rdata;
    logic signed [31:0] back;
    logic signed [31:0] min;
    logic signed [31:0] max;
  } carry_t;

endpackage

@@ rtl/core/bdq_cell.sv @@
// One deque cell: holds an entry and runs one stage of the summary scan.
`timescale 1ns / 1ps
module bdq_cell (
  input  logic                   clk,
  input  logic [bdq_pkg::IDX_W-1:0] idx,
  input  bdq_pkg::cell_cmd_t     cmd,
  input  logic signed [31:0]     left_entry,
  input  logic signed [31:0]     right_entry,
  input  bdq_pkg::scan_ctx_t     ctx,
  input  bdq_pkg::carry_t        carry_in,
  output bdq_pkg::carry_t        carry_out,
  output logic signed [31:0]     entry
);

  logic signed [31:0] entry_next;
  bdq_pkg::carry_t    carry_next;
  logic               live;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      bdq_pkg::CELL_INSERT_FRONT: begin
        entry_next = (idx == '0) ? cmd.data : left_entry;
      end
      bdq_pkg::CELL_WRITE_AT: begin
        if (idx == cmd.at) entry_next = cmd.data;
      end
      bdq_pkg::CELL_SHIFT_FROM: begin
        if (idx >= cmd.at) entry_next = right_entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // scan stage: fold this entry into the wavefront from the front cell
  always_comb begin
    live       = {1'b0, idx} < ctx.count;
    carry_next = carry_in;
    if (live) begin
      if (!carry_in.any) begin
        carry_next.min = entry;
        carry_next.max = entry;
      end else begin
        if (entry < carry_in.min) carry_next.min = entry;
        if (entry > carry_in.max) carry_next.max = entry;
      end
      carry_next.any  = 1'b1;
      carry_next.back = entry;
      if (idx == ctx.pos) carry_next.rdata = entry;
      if (!carry_in.found && entry == ctx.key) begin
        carry_next.found = 1'b1;
        carry_next.fpos  = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

@@ rtl/core/bounded_deque_with_search.sv @@
// Top level of the bounded deque with search: control, status and the cell chain.
// Usage:
//   Input channel (in_valid/in_ready) carries one word: action, value, position.
//   Output channel (out_valid/out_ready) returns one result word per input word:
//   status, read data, found index, occupancy, front, back, minimum, maximum.
//   The cells update at the accepting edge; the summary then travels down the
//   chain of DEPTH cells, one cell per cycle, and the result is registered when
//   the scan finishes.
//   One word is worked on at a time: the next word is taken only once the
//   scan of the previous one has finished and its result is registered.
//   The result sits in an output register; a new word may be accepted while
//   it waits. If the receiver stalls, the finished scan holds until the
//   output register frees, and in_ready stays low meanwhile.
//   Reset empties the deque and clears out_valid; entry storage is not
//   cleared, as only entries below the fill count are ever read.
`timescale 1ns / 1ps
module bounded_deque_with_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic [4:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] read_data,
  output logic [4:0]         found_position,
  output logic [5:0]         occupancy,
  output logic signed [31:0] front_entry,
  output logic signed [31:0] back_entry,
  output logic signed [31:0] smallest,
  output logic signed [31:0] largest
);

  localparam int DEPTH = bdq_pkg::DEPTH;
  localparam int IDX_W = bdq_pkg::IDX_W;
  localparam int CNT_W = bdq_pkg::CNT_W;
  localparam int CMP_W = bdq_pkg::CMP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     scan_cnt;
  logic [2:0]           act_q;
  logic [2:0]           status_q;
  logic [2:0]           status_next;
  logic signed [31:0]   key_q;
  logic [IDX_W-1:0]     pos_q;
  logic                 accept;
  logic                 finish;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     count_ext;
  logic [CMP_W-1:0]     fpos_ext;
  logic [CMP_W-1:0]     occ_ext;
  logic                 is_full;
  logic                 is_empty;
  logic                 in_range;

  bdq_pkg::cell_cmd_t   cmd;
  bdq_pkg::scan_ctx_t   ctx;
  bdq_pkg::carry_t      carry_head;
  bdq_pkg::carry_t      carry   [DEPTH];
  logic signed [31:0]   entries [DEPTH];
  bdq_pkg::carry_t      last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_SCAN) && (scan_cnt == '0) && (!out_valid || out_ready);

  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign in_range  = pos_ext < count_ext;

  always_comb begin
    cmd         = '0;
    cmd.op      = bdq_pkg::CELL_HOLD;
    cmd.data    = value;
    count_next  = count;
    status_next = bdq_pkg::ST_OK;
    if (accept) begin
      case (action)
        bdq_pkg::ACT_PUSH_FRONT: begin
          if (is_full) begin
            status_next = bdq_pkg::ST_FULL;
          end else begin
            cmd.op     = bdq_pkg::CELL_INSERT_FRONT;
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::ACT_PUSH_BACK: begin
          if (is_full) begin
            status_next = bdq_pkg::ST_FULL;
          end else begin
            cmd.op     = bdq_pkg::CELL_WRITE_AT;
            cmd.at     = count[IDX_W-1:0];
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::ACT_POP_FRONT: begin
          if (is_empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else begin
            cmd.op     = bdq_pkg::CELL_SHIFT_FROM;
            cmd.at     = '0;
            count_next = count - 1'b1;
          end
        end
        bdq_pkg::ACT_POP_BACK: begin
          if (is_empty) status_next = bdq_pkg::ST_EMPTY;
          else count_next = count - 1'b1;
        end
        bdq_pkg::ACT_READ_AT: begin
          if (is_empty) status_next = bdq_pkg::ST_EMPTY;
          else if (!in_range) status_next = bdq_pkg::ST_RANGE;
        end
        bdq_pkg::ACT_REMOVE_AT: begin
          if (is_empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else if (!in_range) begin
            status_next = bdq_pkg::ST_RANGE;
          end else begin
            cmd.op     = bdq_pkg::CELL_SHIFT_FROM;
            cmd.at     = pos_ext[IDX_W-1:0];
            count_next = count - 1'b1;
          end
        end
        default: status_next = bdq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        state    <= S_SCAN;
        scan_cnt <= CNT_W'(DEPTH);
      end else if (state == S_SCAN && scan_cnt != '0) begin
        scan_cnt <= scan_cnt - 1'b1;
      end else if (finish) begin
        state <= S_IDLE;
      end
      if (finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= action;
      status_q <= status_next;
      key_q    <= value;
      pos_q    <= pos_ext[IDX_W-1:0];
    end
  end

  assign ctx.count  = count;
  assign ctx.key    = key_q;
  assign ctx.pos    = pos_q;
  assign carry_head = '0;

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_e;
      logic signed [31:0] right_e;
      bdq_pkg::carry_t    cin;
      if (g == 0) begin : g_head
        assign left_e = value;
        assign cin    = carry_head;
      end else begin : g_mid
        assign left_e = entries[g-1];
        assign cin    = carry[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign right_e = entries[g];
      end else begin : g_body
        assign right_e = entries[g+1];
      end
      bdq_cell u_cell (
        .clk         (clk),
        .idx         (IDX_W'(g)),
        .cmd         (cmd),
        .left_entry  (left_e),
        .right_entry (right_e),
        .ctx         (ctx),
        .carry_in    (cin),
        .carry_out   (carry[g]),
        .entry       (entries[g])
      );
    end
  endgenerate

  assign last     = carry[DEPTH-1];
  assign fpos_ext = CMP_W'(last.fpos);
  assign occ_ext  = CMP_W'(count);

  always_ff @(posedge clk) begin
    if (finish) begin
      occupancy   <= occ_ext[5:0];
      front_entry <= (count != '0) ? entries[0] : '0;
      back_entry  <= last.any ? last.back : '0;
      smallest    <= last.any ? last.min : '0;
      largest     <= last.any ? last.max : '0;
      read_data   <= (act_q == bdq_pkg::ACT_READ_AT && status_q == bdq_pkg::ST_OK) ?
                     last.rdata : '0;
      if (act_q == bdq_pkg::ACT_FIND) begin
        status         <= last.found ? bdq_pkg::ST_OK : bdq_pkg::ST_NOTFOUND;
        found_position <= last.found ? fpos_ext[4:0] : '0;
      end else begin
        status         <= status_q;
        found_position <= '0;
      end
    end
  end

endmodule
